[rtl/core/msa_pkg.sv]
// ----------------------------------------------------------------------------
// msa_pkg
// Shared types and constants of the matrix scan averager.
// ----------------------------------------------------------------------------
package msa_pkg;

  // parameter defaults
  localparam int NUM_ROWS_DEF        = 16;
  localparam int NUM_COLUMNS_DEF     = 16;
  localparam int MAX_SUPERSAMPLE_DEF = 32;
  localparam int SAMPLE_BITS_DEF     = 12;

  // fixed field widths
  localparam int OP_W       = 2;
  localparam int ROWCOL_W   = 4;
  localparam int SS_CFG_W   = 6;
  localparam int SETTLE_W   = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  // queue between front and back
  localparam int JOBQ_DEPTH = 4;

  // reset value of supersample_count
  localparam logic [SS_CFG_W-1:0] SS_RESET = SS_CFG_W'(1);

  // input opcodes
  localparam logic [OP_W-1:0] OP_START  = 2'd0;
  localparam logic [OP_W-1:0] OP_TICK   = 2'd1;
  localparam logic [OP_W-1:0] OP_SAMPLE = 2'd2;

  // result kinds
  localparam logic KIND_ROW   = 1'b0;
  localparam logic KIND_POINT = 1'b1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_SUPERSAMPLE = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETTLE      = 2'd1;

  // everything of a result item except the value
  typedef struct packed {
    logic                kind;
    logic                last;
    logic [ROWCOL_W-1:0] row;
    logic [ROWCOL_W-1:0] column;
  } msa_tag_t;

endpackage

[rtl/core/msa_jobq.sv]
// ----------------------------------------------------------------------------
// msa_jobq
// Small FIFO carrying jobs from the scan front to the divide back.
// ----------------------------------------------------------------------------
module msa_jobq #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  logic [DATA_W-1:0] push_data,
  input  logic              pop,
  output logic [DATA_W-1:0] pop_data,
  output logic              full,
  output logic              empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] mem [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_r;
  logic [PTR_W-1:0]  rd_ptr_r;
  logic [CNT_W-1:0]  count_r;
  logic              do_push;
  logic              do_pop;

  assign full     = (count_r == CNT_W'(DEPTH));
  assign empty    = (count_r == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_data;
    end
  end

endmodule

[rtl/core/msa_front.sv]
// ----------------------------------------------------------------------------
// msa_front
// Scan sequencer: config registers, settle timer, row/column walk and
// sample accumulation. Emits one job per row select or finished point.
// ----------------------------------------------------------------------------
module msa_front #(
  parameter int NUM_ROWS        = 16,
  parameter int NUM_COLUMNS     = 16,
  parameter int MAX_SUPERSAMPLE = 32,
  parameter int SAMPLE_BITS     = 12
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [msa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [msa_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                              in_accept,
  input  logic [msa_pkg::OP_W-1:0]          in_op,
  input  logic [SAMPLE_BITS-1:0]            in_raw_sample,
  output logic                              job_push,
  output msa_pkg::msa_tag_t                 job_tag,
  output logic [SAMPLE_BITS+$clog2(MAX_SUPERSAMPLE)-1:0] job_sum,
  output logic [$clog2(MAX_SUPERSAMPLE+1)-1:0]           job_cnt
);

  import msa_pkg::*;

  localparam int SUM_W = SAMPLE_BITS + $clog2(MAX_SUPERSAMPLE);
  localparam int CNT_W = $clog2(MAX_SUPERSAMPLE + 1);
  localparam int CMP_W = (CNT_W > SS_CFG_W) ? CNT_W : SS_CFG_W;
  localparam int ROW_W = (NUM_ROWS > 1) ? $clog2(NUM_ROWS) : 1;
  localparam int COL_W = (NUM_COLUMNS > 1) ? $clog2(NUM_COLUMNS) : 1;

  localparam logic [1:0] PH_IDLE   = 2'd0;
  localparam logic [1:0] PH_SETTLE = 2'd1;
  localparam logic [1:0] PH_SAMPLE = 2'd2;

  logic [SS_CFG_W-1:0] ss_cfg_r;
  logic [SETTLE_W-1:0] settle_cfg_r;

  logic [1:0]          phase_r,   phase_nxt;
  logic [SETTLE_W-1:0] settle_r,  settle_nxt;
  logic [ROW_W-1:0]    row_r,     row_nxt;
  logic [COL_W-1:0]    col_r,     col_nxt;
  logic [CNT_W-1:0]    taken_r,   taken_nxt;
  logic [SUM_W-1:0]    sum_r,     sum_nxt;

  logic [CMP_W-1:0]         ss_ext;
  logic [CMP_W-1:0]         eff_cmp;
  logic [CNT_W-1:0]         eff_cnt;
  logic [SUM_W-1:0]         new_sum;
  logic [CNT_W-1:0]         taken_inc;
  logic [1:0]               entry_phase;
  logic                     last_row;
  logic                     last_col;
  logic [ROW_W+ROWCOL_W-1:0] row_ext;
  logic [COL_W+ROWCOL_W-1:0] col_ext;

  // clamp count to 1..MAX_SUPERSAMPLE
  assign ss_ext  = CMP_W'(ss_cfg_r);
  assign eff_cmp = (ss_ext == '0) ? CMP_W'(1) :
                   (ss_ext > CMP_W'(MAX_SUPERSAMPLE)) ? CMP_W'(MAX_SUPERSAMPLE) : ss_ext;
  assign eff_cnt = eff_cmp[CNT_W-1:0];

  assign new_sum     = sum_r + SUM_W'(in_raw_sample);
  assign taken_inc   = taken_r + 1'b1;
  assign entry_phase = (settle_cfg_r == '0) ? PH_SAMPLE : PH_SETTLE;
  assign last_row    = (row_r == ROW_W'(NUM_ROWS - 1));
  assign last_col    = (col_r == COL_W'(NUM_COLUMNS - 1));
  assign row_ext     = {{ROWCOL_W{1'b0}}, row_r};
  assign col_ext     = {{ROWCOL_W{1'b0}}, col_r};

  always_comb begin
    phase_nxt      = phase_r;
    settle_nxt     = settle_r;
    row_nxt        = row_r;
    col_nxt        = col_r;
    taken_nxt      = taken_r;
    sum_nxt        = sum_r;
    job_push       = 1'b0;
    job_tag        = '0;
    job_sum        = new_sum;
    job_cnt        = eff_cnt;

    if (in_accept) begin
      case (in_op)
        OP_START: begin
          if (phase_r == PH_IDLE) begin
            row_nxt    = '0;
            col_nxt    = '0;
            taken_nxt  = '0;
            sum_nxt    = '0;
            settle_nxt = settle_cfg_r;
            phase_nxt  = entry_phase;
            job_push   = 1'b1;
            job_tag.kind = KIND_ROW;
            job_sum    = '0;
          end
        end
        OP_TICK: begin
          if (phase_r == PH_SETTLE) begin
            if (settle_r != '0) begin
              settle_nxt = settle_r - 1'b1;
            end
            if (settle_r <= SETTLE_W'(1)) begin
              phase_nxt = PH_SAMPLE;
            end
          end
        end
        OP_SAMPLE: begin
          if (phase_r == PH_SAMPLE) begin
            if (taken_inc < eff_cnt) begin
              taken_nxt = taken_inc;
              sum_nxt   = new_sum;
            end else begin
              job_push       = 1'b1;
              job_tag.kind   = KIND_POINT;
              job_tag.last   = last_row && last_col;
              job_tag.row    = row_ext[ROWCOL_W-1:0];
              job_tag.column = col_ext[ROWCOL_W-1:0];
              taken_nxt      = '0;
              sum_nxt        = '0;
              if (!last_col) begin
                col_nxt = col_r + 1'b1;
              end else if (!last_row) begin
                row_nxt    = row_r + 1'b1;
                col_nxt    = '0;
                settle_nxt = settle_cfg_r;
                phase_nxt  = entry_phase;
              end else begin
                phase_nxt  = PH_IDLE;
                row_nxt    = '0;
                col_nxt    = '0;
                settle_nxt = '0;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ss_cfg_r     <= SS_RESET;
      settle_cfg_r <= '0;
      phase_r      <= PH_IDLE;
      settle_r     <= '0;
      row_r        <= '0;
      col_r        <= '0;
      taken_r      <= '0;
      sum_r        <= '0;
    end else begin
      if (cfg_we && cfg_index == REG_SUPERSAMPLE) begin
        ss_cfg_r <= cfg_data[SS_CFG_W-1:0];
      end
      if (cfg_we && cfg_index == REG_SETTLE) begin
        settle_cfg_r <= cfg_data[SETTLE_W-1:0];
      end
      phase_r  <= phase_nxt;
      settle_r <= settle_nxt;
      row_r    <= row_nxt;
      col_r    <= col_nxt;
      taken_r  <= taken_nxt;
      sum_r    <= sum_nxt;
    end
  end

endmodule

[rtl/core/msa_back.sv]
// ----------------------------------------------------------------------------
// msa_back
// Takes jobs, divides sample sums by the count one quotient bit a cycle,
// and holds the finished item in the output register.
// ----------------------------------------------------------------------------
module msa_back #(
  parameter int MAX_SUPERSAMPLE = 32,
  parameter int SAMPLE_BITS     = 12
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 job_valid,
  output logic                                 job_pop,
  input  msa_pkg::msa_tag_t                    job_tag,
  input  logic [SAMPLE_BITS+$clog2(MAX_SUPERSAMPLE)-1:0] job_sum,
  input  logic [$clog2(MAX_SUPERSAMPLE+1)-1:0]           job_cnt,
  input  logic                                 out_pop,
  output logic                                 out_empty,
  output logic                                 out_kind,
  output logic [msa_pkg::ROWCOL_W-1:0]         out_row,
  output logic [msa_pkg::ROWCOL_W-1:0]         out_column,
  output logic [SAMPLE_BITS-1:0]               out_value,
  output logic                                 out_last_of_frame
);

  import msa_pkg::*;

  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_SUPERSAMPLE);
  localparam int CNT_W  = $clog2(MAX_SUPERSAMPLE + 1);
  localparam int STEP_W = $clog2(SUM_W + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_DIV  = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]          st_r;
  logic [STEP_W-1:0]   step_r;
  logic                out_valid_r;
  msa_tag_t            tag_r;
  msa_tag_t            out_tag_r;
  logic [SUM_W-1:0]    quo_r;
  logic [CNT_W-1:0]    rem_r;
  logic [CNT_W-1:0]    div_r;
  logic [SAMPLE_BITS-1:0] out_value_r;

  logic [CNT_W:0]      shifted;
  logic [CNT_W:0]      diff;
  logic                ge;
  logic                out_free;
  logic                load_out;

  // restoring divide step
  assign shifted  = {rem_r, quo_r[SUM_W-1]};
  assign ge       = (shifted >= {1'b0, div_r});
  assign diff     = shifted - {1'b0, div_r};

  assign out_free = !out_valid_r || out_pop;
  assign load_out = (st_r == ST_DONE) && out_free;
  assign job_pop  = (st_r == ST_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      case (st_r)
        ST_IDLE: begin
          if (job_valid) begin
            step_r <= STEP_W'(SUM_W);
            st_r   <= (job_tag.kind == KIND_POINT) ? ST_DIV : ST_DONE;
          end
        end
        ST_DIV: begin
          step_r <= step_r - 1'b1;
          if (step_r == STEP_W'(1)) begin
            st_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            st_r <= ST_IDLE;
          end
        end
        default: begin
          st_r <= ST_IDLE;
        end
      endcase
      if (load_out) begin
        out_valid_r <= 1'b1;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      tag_r <= job_tag;
      quo_r <= job_sum;
      rem_r <= '0;
      div_r <= job_cnt;
    end else if (st_r == ST_DIV) begin
      quo_r <= {quo_r[SUM_W-2:0], ge};
      rem_r <= ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
    end
    if (load_out) begin
      out_tag_r   <= tag_r;
      out_value_r <= quo_r[SAMPLE_BITS-1:0];
    end
  end

  assign out_empty         = !out_valid_r;
  assign out_kind          = out_tag_r.kind;
  assign out_row           = out_tag_r.row;
  assign out_column        = out_tag_r.column;
  assign out_value         = out_value_r;
  assign out_last_of_frame = out_tag_r.last;

endmodule

[rtl/core/matrix_scan_supersample_averager_top.sv]
// ----------------------------------------------------------------------------
// matrix_scan_supersample_averager_top
// Sensor matrix frame scanner with per-point sample averaging.
// ----------------------------------------------------------------------------
// A start item (op 0) while idle begins a frame and yields a row select item
// for row 0. After every row switch the block counts settle_ticks tick items
// (op 1), then takes supersample_count raw samples (op 2) per column and yields
// one point item per column: floor(sum / count) with its row and column. The
// final point of the frame has last_of_frame set, and the block returns to
// idle. Items that do not fit the current phase are taken and dropped.
// Rate: the input side takes one item per cycle while the job queue has room
// (JOBQ_DEPTH entries). Each point result then goes through the divider, one
// quotient bit for each of the SUM_W bits of its sum (SUM_W = SAMPLE_BITS +
// log2(MAX_SUPERSAMPLE)); a row select skips it. The restoring divider takes
// one job at a time, one quotient bit per cycle, and sets the sustained result rate.
// Configuration writes are always accepted (cfg_ready is tied high); index 0
// is supersample_count (0 acts as 1, values above MAX_SUPERSAMPLE are
// clamped), index 1 is settle_ticks; other indexes are ignored.
// ----------------------------------------------------------------------------
module matrix_scan_supersample_averager_top #(
  parameter int NUM_ROWS        = msa_pkg::NUM_ROWS_DEF,
  parameter int NUM_COLUMNS     = msa_pkg::NUM_COLUMNS_DEF,
  parameter int MAX_SUPERSAMPLE = msa_pkg::MAX_SUPERSAMPLE_DEF,
  parameter int SAMPLE_BITS     = msa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // configuration
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [msa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msa_pkg::CFG_DATA_W-1:0] cfg_data,
  // input items
  input  logic                           push,
  output logic                           full,
  input  logic [msa_pkg::OP_W-1:0]       in_op,
  input  logic [SAMPLE_BITS-1:0]         in_raw_sample,
  // result items
  output logic                           empty,
  input  logic                           pop,
  output logic                           out_kind,
  output logic [msa_pkg::ROWCOL_W-1:0]   out_row,
  output logic [msa_pkg::ROWCOL_W-1:0]   out_column,
  output logic [SAMPLE_BITS-1:0]         out_value,
  output logic                           out_last_of_frame
);

  import msa_pkg::*;

  localparam int SUM_W  = SAMPLE_BITS + $clog2(MAX_SUPERSAMPLE);
  localparam int CNT_W  = $clog2(MAX_SUPERSAMPLE + 1);
  localparam int TAG_W  = $bits(msa_tag_t);
  localparam int JOB_W  = TAG_W + SUM_W + CNT_W;

  logic              in_accept;
  logic              job_push;
  msa_tag_t          job_tag;
  logic [SUM_W-1:0]  job_sum;
  logic [CNT_W-1:0]  job_cnt;
  logic [JOB_W-1:0]  q_in;
  logic [JOB_W-1:0]  q_out;
  logic              q_empty;
  logic              q_pop;
  msa_tag_t          q_tag;
  logic [SUM_W-1:0]  q_sum;
  logic [CNT_W-1:0]  q_cnt;

  assign cfg_ready = 1'b1;
  assign in_accept = push && !full;

  // front: sequencer and accumulator
  msa_front #(
    .NUM_ROWS        (NUM_ROWS),
    .NUM_COLUMNS     (NUM_COLUMNS),
    .MAX_SUPERSAMPLE (MAX_SUPERSAMPLE),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg_we        (cfg_valid && cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .in_accept     (in_accept),
    .in_op         (in_op),
    .in_raw_sample (in_raw_sample),
    .job_push      (job_push),
    .job_tag       (job_tag),
    .job_sum       (job_sum),
    .job_cnt       (job_cnt)
  );

  // job queue; its full flag throttles the input side
  assign q_in = {job_tag, job_sum, job_cnt};

  msa_jobq #(
    .DATA_W (JOB_W),
    .DEPTH  (JOBQ_DEPTH)
  ) u_jobq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (job_push),
    .push_data (q_in),
    .pop       (q_pop),
    .pop_data  (q_out),
    .full      (full),
    .empty     (q_empty)
  );

  assign q_tag = q_out[JOB_W-1 -: TAG_W];
  assign q_sum = q_out[CNT_W +: SUM_W];
  assign q_cnt = q_out[CNT_W-1:0];

  // back: divider and output register
  msa_back #(
    .MAX_SUPERSAMPLE (MAX_SUPERSAMPLE),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .job_valid         (!q_empty),
    .job_pop           (q_pop),
    .job_tag           (q_tag),
    .job_sum           (q_sum),
    .job_cnt           (q_cnt),
    .out_pop           (pop),
    .out_empty         (empty),
    .out_kind          (out_kind),
    .out_row           (out_row),
    .out_column        (out_column),
    .out_value         (out_value),
    .out_last_of_frame (out_last_of_frame)
  );

endmodule

[rtl/core/msa_checker.sv]
// ----------------------------------------------------------------------------
// msa_checker
// Port-level checks of the matrix scan averager, bound to the top level.
// ----------------------------------------------------------------------------
module msa_checker #(
  parameter int NUM_ROWS    = 16,
  parameter int NUM_COLUMNS = 16,
  parameter int SAMPLE_BITS = 12
) (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           full,
  input logic                           empty,
  input logic                           pop,
  input logic                           out_kind,
  input logic [msa_pkg::ROWCOL_W-1:0]   out_row,
  input logic [msa_pkg::ROWCOL_W-1:0]   out_column,
  input logic [SAMPLE_BITS-1:0]         out_value,
  input logic                           out_last_of_frame
);

  import msa_pkg::*;

  localparam logic [ROWCOL_W-1:0] LAST_ROW = ROWCOL_W'(NUM_ROWS - 1);
  localparam logic [ROWCOL_W-1:0] LAST_COL = ROWCOL_W'(NUM_COLUMNS - 1);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> empty && !full)
    else $error("queues not empty after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && !pop |=> !empty && $stable(out_value) && $stable(out_row)
      && $stable(out_column) && $stable(out_kind))
    else $error("waiting item changed");

  a_row_select_clean: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_kind == KIND_ROW |->
      out_column == '0 && out_value == '0 && !out_last_of_frame)
    else $error("row select carries point data");

  a_last_position: assert property (@(posedge clk) disable iff (!rst_n)
    !empty && out_last_of_frame |->
      out_kind == KIND_POINT && out_row == LAST_ROW && out_column == LAST_COL)
    else $error("last_of_frame on wrong point");

endmodule

bind matrix_scan_supersample_averager_top msa_checker #(
  .NUM_ROWS    (NUM_ROWS),
  .NUM_COLUMNS (NUM_COLUMNS),
  .SAMPLE_BITS (SAMPLE_BITS)
) u_msa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .full              (full),
  .empty             (empty),
  .pop               (pop),
  .out_kind          (out_kind),
  .out_row           (out_row),
  .out_column        (out_column),
  .out_value         (out_value),
  .out_last_of_frame (out_last_of_frame)
);

[tb/msa_scan_checker.sv]
// ----------------------------------------------------------------------------
// msa_scan_checker
// Watches the channels of the matrix scan averager, keeps its own scan state
// and compares every result item with the oldest one it expects.
// ----------------------------------------------------------------------------
module msa_scan_checker #(
  parameter int NUM_ROWS        = msa_pkg::NUM_ROWS_DEF,
  parameter int NUM_COLUMNS     = msa_pkg::NUM_COLUMNS_DEF,
  parameter int MAX_SUPERSAMPLE = msa_pkg::MAX_SUPERSAMPLE_DEF,
  parameter int SAMPLE_BITS     = msa_pkg::SAMPLE_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [msa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [msa_pkg::CFG_DATA_W-1:0] cfg_data,
  input  logic                           push,
  input  logic                           full,
  input  logic [msa_pkg::OP_W-1:0]       in_op,
  input  logic [SAMPLE_BITS-1:0]         in_raw_sample,
  input  logic                           empty,
  input  logic                           pop,
  input  logic                           out_kind,
  input  logic [msa_pkg::ROWCOL_W-1:0]   out_row,
  input  logic [msa_pkg::ROWCOL_W-1:0]   out_column,
  input  logic [SAMPLE_BITS-1:0]         out_value,
  input  logic                           out_last_of_frame,
  output int                             pending_results,
  output int                             fail_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import msa_pkg::*;

  typedef enum logic [1:0] {SCAN_IDLE, SCAN_SETTLE, SCAN_SAMPLE} scan_phase_t;

  typedef struct packed {
    logic                   kind;
    logic [ROWCOL_W-1:0]    row;
    logic [ROWCOL_W-1:0]    column;
    logic [SAMPLE_BITS-1:0] value;
    logic                   last;
  } point_item_t;

  scan_phase_t         phase;
  logic [SETTLE_W-1:0] settle_left;
  logic [SETTLE_W-1:0] settle_cfg;
  logic [SS_CFG_W-1:0] ss_count;
  int                  row_idx;
  int                  col_idx;
  int                  taken;
  int                  acc;
  int                  errors = 0;
  point_item_t         awaited[$];

  task automatic open_scan_row();
    col_idx = 0;
    taken   = 0;
    acc     = 0;
    if (settle_cfg == '0) begin
      phase = SCAN_SAMPLE;
    end else begin
      settle_left = settle_cfg;
      phase       = SCAN_SETTLE;
    end
  endtask

  task automatic scan_accept(input logic [OP_W-1:0] op, input logic [SAMPLE_BITS-1:0] raw);
    point_item_t r;
    int          cnt;
    r = '0;
    case (op)
      OP_START: begin
        if (phase == SCAN_IDLE) begin
          row_idx = 0;
          open_scan_row();
          r.kind = KIND_ROW;
          awaited.push_back(r);
        end
      end
      OP_TICK: begin
        if (phase == SCAN_SETTLE) begin
          if (settle_left != '0) settle_left = settle_left - 1'b1;
          if (settle_left == '0) phase = SCAN_SAMPLE;
        end
      end
      OP_SAMPLE: begin
        if (phase == SCAN_SAMPLE) begin
          cnt = int'(ss_count);
          if (cnt == 0) cnt = 1;
          if (cnt > MAX_SUPERSAMPLE) cnt = MAX_SUPERSAMPLE;
          acc   = acc + int'(raw);
          taken = taken + 1;
          if (taken >= cnt) begin
            r.kind   = KIND_POINT;
            r.row    = ROWCOL_W'(row_idx);
            r.column = ROWCOL_W'(col_idx);
            r.value  = SAMPLE_BITS'(acc / cnt);
            r.last   = (row_idx + 1 >= NUM_ROWS) && (col_idx + 1 >= NUM_COLUMNS);
            awaited.push_back(r);
            taken = 0;
            acc   = 0;
            if (col_idx + 1 < NUM_COLUMNS) begin
              col_idx = col_idx + 1;
            end else if (row_idx + 1 < NUM_ROWS) begin
              row_idx = row_idx + 1;
              open_scan_row();
            end else begin
              phase       = SCAN_IDLE;
              row_idx     = 0;
              col_idx     = 0;
              settle_left = '0;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic flag_field(input string name, input int want, input int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      errors++;
    end
  endtask

  task automatic check_result();
    point_item_t want;
    if (awaited.size() == 0) begin
      $display("%0t: unexpected result item kind %0d row %0d column %0d value %0d last %0d",
               $time, out_kind, out_row, out_column, out_value, out_last_of_frame);
      errors++;
    end else begin
      want = awaited.pop_front();
      flag_field("kind", want.kind, out_kind);
      flag_field("row", want.row, out_row);
      flag_field("column", want.column, out_column);
      flag_field("value", want.value, out_value);
      flag_field("last_of_frame", want.last, out_last_of_frame);
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      phase       = SCAN_IDLE;
      settle_left = '0;
      settle_cfg  = '0;
      ss_count    = SS_RESET;
      row_idx     = 0;
      col_idx     = 0;
      taken       = 0;
      acc         = 0;
      awaited.delete();
    end else begin
      if (pop && !empty) check_result();
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_SUPERSAMPLE) ss_count = cfg_data[SS_CFG_W-1:0];
        else if (cfg_index == REG_SETTLE) settle_cfg = cfg_data[SETTLE_W-1:0];
      end
      if (push && !full) scan_accept(in_op, in_raw_sample);
    end
    pending_results <= awaited.size();
    fail_count      <= errors;
  end

endmodule

[tb/matrix_scan_supersample_averager_top_tb.sv]
// ----------------------------------------------------------------------------
// matrix_scan_supersample_averager_top_tb
// Drives start, tick and sample items plus register writes into the matrix
// scan averager and lets msa_scan_checker compare every result item.
// ----------------------------------------------------------------------------
module matrix_scan_supersample_averager_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import msa_pkg::*;

  localparam int NUM_ROWS        = NUM_ROWS_DEF;
  localparam int NUM_COLUMNS     = NUM_COLUMNS_DEF;
  localparam int MAX_SUPERSAMPLE = MAX_SUPERSAMPLE_DEF;
  localparam int SAMPLE_BITS     = SAMPLE_BITS_DEF;

  // op code with no meaning, register indexes with no register behind them
  localparam logic [OP_W-1:0]      OP_NONE    = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_2 = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_NONE_3 = 2'd3;

  localparam int RANDOM_ITEMS = 1750;
  // cycles to let the job queue and divider run dry before a register write
  localparam int DRAIN_CYCLES = 100;
  // random items sent with neither side stalling
  localparam int CALM_FIRST   = 700;
  localparam int CALM_LAST    = 1000;

  logic                   clk           = 1'b0;
  logic                   rst_n         = 1'b0;
  logic                   cfg_valid     = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index     = '0;
  logic [CFG_DATA_W-1:0]  cfg_data      = '0;
  logic                   push          = 1'b0;
  logic                   full;
  logic [OP_W-1:0]        in_op         = OP_START;
  logic [SAMPLE_BITS-1:0] in_raw_sample = '0;
  logic                   empty;
  logic                   pop           = 1'b0;
  logic                   out_kind;
  logic [ROWCOL_W-1:0]    out_row;
  logic [ROWCOL_W-1:0]    out_column;
  logic [SAMPLE_BITS-1:0] out_value;
  logic                   out_last_of_frame;
  int                     pending_results;
  int                     fail_count;
  logic                   calm          = 1'b0;

  // Where the scan stands after the items sent so far. Used only to pick the
  // item that moves the frame forward; the checker owns the expected results.
  bit gen_busy      = 1'b0;
  int gen_ticks_left = 0;
  int gen_row       = 0;
  int gen_col       = 0;
  int gen_taken     = 0;
  int gen_count     = 1;
  int gen_settle    = 0;
  int config_rounds = 0;

  always #6 clk = ~clk;

  matrix_scan_supersample_averager_top i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .push              (push),
    .full              (full),
    .in_op             (in_op),
    .in_raw_sample     (in_raw_sample),
    .empty             (empty),
    .pop               (pop),
    .out_kind          (out_kind),
    .out_row           (out_row),
    .out_column        (out_column),
    .out_value         (out_value),
    .out_last_of_frame (out_last_of_frame)
  );

  msa_scan_checker #(
    .NUM_ROWS        (NUM_ROWS),
    .NUM_COLUMNS     (NUM_COLUMNS),
    .MAX_SUPERSAMPLE (MAX_SUPERSAMPLE),
    .SAMPLE_BITS     (SAMPLE_BITS)
  ) i_checker (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .push              (push),
    .full              (full),
    .in_op             (in_op),
    .in_raw_sample     (in_raw_sample),
    .empty             (empty),
    .pop               (pop),
    .out_kind          (out_kind),
    .out_row           (out_row),
    .out_column        (out_column),
    .out_value         (out_value),
    .out_last_of_frame (out_last_of_frame),
    .pending_results   (pending_results),
    .fail_count        (fail_count)
  );

  // Result side: take items about 79 times in 100, always during the calm stretch.
  always @(posedge clk) begin
    if (!rst_n) begin
      pop <= 1'b0;
    end else begin
      pop <= calm || ($urandom_range(0, 99) >= 21);
    end
  end

  task automatic open_gen_row();
    gen_col        = 0;
    gen_taken      = 0;
    gen_ticks_left = gen_settle;
  endtask

  // Advance the scan position by one accepted item.
  task automatic track_item(input logic [OP_W-1:0] op);
    case (op)
      OP_START: begin
        if (!gen_busy) begin
          gen_busy = 1'b1;
          gen_row  = 0;
          open_gen_row();
        end
      end
      OP_TICK: begin
        if (gen_busy && gen_ticks_left > 0) gen_ticks_left--;
      end
      OP_SAMPLE: begin
        if (gen_busy && gen_ticks_left == 0) begin
          gen_taken++;
          // a count lowered mid-point closes the point at once
          if (gen_taken >= gen_count) begin
            gen_taken = 0;
            if (gen_col < NUM_COLUMNS - 1) begin
              gen_col++;
            end else if (gen_row < NUM_ROWS - 1) begin
              gen_row++;
              open_gen_row();
            end else begin
              gen_busy = 1'b0;
            end
          end
        end
      end
      default: ;
    endcase
  endtask

  // One input item: random gaps first, then hold push until the item is taken.
  // push is never lowered at the end, so back-to-back items keep it high.
  task automatic send_item(input logic [OP_W-1:0] op, input logic [SAMPLE_BITS-1:0] raw);
    while (!calm && $urandom_range(0, 99) < 21) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push          <= 1'b1;
    in_op         <= op;
    in_raw_sample <= raw;
    do @(posedge clk); while (full);
    track_item(op);
  endtask

  // cfg_valid stays high across back-to-back writes; the caller lowers it.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // Registers change only with nothing in flight: wait for the last expected
  // result, then let the block run dry before writing.
  task automatic set_config(input logic [CFG_DATA_W-1:0] count_word,
                            input logic [CFG_DATA_W-1:0] settle_word);
    int c;
    push <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    // longest settle time, overwritten before any row switch can load it
    if (config_rounds == 0 || $urandom_range(0, 9) == 0) write_reg(REG_SETTLE, '1);
    if (config_rounds == 0) begin
      write_reg(REG_NONE_2, '1);
      write_reg(REG_NONE_3, CFG_DATA_W'($urandom));
    end else if ($urandom_range(0, 4) == 0) begin
      write_reg(($urandom_range(0, 1) != 0) ? REG_NONE_2 : REG_NONE_3,
                CFG_DATA_W'($urandom));
    end
    write_reg(REG_SUPERSAMPLE, count_word);
    write_reg(REG_SETTLE, settle_word);
    cfg_valid <= 1'b0;
    c = int'(count_word[SS_CFG_W-1:0]);
    if (c == 0) c = 1;
    if (c > MAX_SUPERSAMPLE) c = MAX_SUPERSAMPLE;
    gen_count  = c;
    gen_settle = int'(settle_word[SETTLE_W-1:0]);
    config_rounds++;
  endtask

  initial begin : stimulus
    int                     sent;
    int                     seg_len;
    int                     k;
    int                     pick;
    logic [SS_CFG_W-1:0]    c6;
    logic [CFG_DATA_W-1:0]  settle_pick;
    logic [OP_W-1:0]        op;
    logic [SAMPLE_BITS-1:0] raw;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, reset settings: count 1, no settle time.
    send_item(OP_NONE, '1);          // unused op while idle
    send_item(OP_TICK, '0);          // tick while idle
    send_item(OP_SAMPLE, 12'hABC);   // sample while idle
    send_item(OP_START, '1);         // frame start, row select for row 0
    send_item(OP_START, '0);         // start while busy
    send_item(OP_TICK, 12'h555);     // tick while sampling
    send_item(OP_SAMPLE, '1);        // full scale point
    send_item(OP_SAMPLE, '0);        // zero point
    send_item(OP_NONE, '0);

    // count 2 with junk above the 6-bit field: floor rounding at full scale
    set_config({14'h3FFF, 6'd2}, '0);
    send_item(OP_SAMPLE, '1);
    send_item(OP_SAMPLE, 12'hFFE);
    send_item(OP_SAMPLE, 12'd1);
    send_item(OP_SAMPLE, 12'd0);
    // half a point, then the count drops to 0 (acts as 1): closes on next sample
    send_item(OP_SAMPLE, 12'd9);
    set_config('0, '0);
    send_item(OP_SAMPLE, 12'd10);
    send_item(OP_SAMPLE, 12'd7);

    // Random part: well-formed scan traffic with some noise, settings changed
    // between segments, so segments often end mid-point or mid-settle.
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 55)      c6 = 6'd1;
      else if (pick < 70) c6 = 6'd2;
      else if (pick < 78) c6 = 6'd3;
      else if (pick < 84) c6 = 6'd0;
      else if (pick < 88) c6 = 6'(MAX_SUPERSAMPLE);
      else if (pick < 93) c6 = 6'($urandom_range(33, 63));   // clamped
      else                c6 = 6'($urandom_range(4, 31));
      pick = $urandom_range(0, 99);
      if (pick < 40)      settle_pick = '0;
      else if (pick < 75) settle_pick = CFG_DATA_W'($urandom_range(1, 3));
      else                settle_pick = CFG_DATA_W'($urandom_range(4, 24));
      set_config({14'($urandom), c6}, settle_pick);

      seg_len = $urandom_range(60, 260);
      for (k = 0; k < seg_len && sent < RANDOM_ITEMS; k++) begin
        calm <= (sent >= CALM_FIRST) && (sent < CALM_LAST);
        // noise: any op, whether it fits the phase or not
        if ($urandom_range(0, 99) < 12) op = OP_W'($urandom_range(0, 3));
        else if (!gen_busy)             op = OP_START;
        else if (gen_ticks_left != 0)   op = OP_TICK;
        else                            op = OP_SAMPLE;
        pick = $urandom_range(0, 9);
        if (pick == 0)      raw = '0;
        else if (pick == 1) raw = '1;
        else                raw = SAMPLE_BITS'($urandom);
        send_item(op, raw);
        sent++;
      end
    end

    push <= 1'b0;
    calm <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Hang guard: several times the slowest legal run.
  initial begin : watchdog
    #5_000_000;
    $display("Some tests failed");
    $finish;
  end

endmodule

[files.f]
rtl/core/msa_pkg.sv
rtl/core/msa_jobq.sv
rtl/core/msa_front.sv
rtl/core/msa_back.sv
rtl/core/matrix_scan_supersample_averager_top.sv
rtl/core/msa_checker.sv
tb/msa_scan_checker.sv
tb/matrix_scan_supersample_averager_top_tb.sv
